/* hdl/bup_pkg.sv */
`default_nettype none

package bup_pkg;

	// Result kinds.
	localparam logic [1:0] KIND_WITHDRAWN = 2'd0;
	localparam logic [1:0] KIND_ANNOUNCED = 2'd1;
	localparam logic [1:0] KIND_DONE      = 2'd2;
	localparam logic [1:0] KIND_ERROR     = 2'd3;

	// Error codes.
	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_SHORT      = 3'd1;
	localparam logic [2:0] ERR_WDR_OVFL   = 3'd2;
	localparam logic [2:0] ERR_PLEN_BIG   = 3'd3;
	localparam logic [2:0] ERR_PFX_OVRRUN = 3'd4;
	localparam logic [2:0] ERR_ATTR_OVFL  = 3'd5;

	// Limits of the message layout.
	localparam logic [7:0]  MAX_PREFIX_BITS = 8'd32;
	localparam logic [15:0] MIN_BODY_BYTES  = 16'd4;

	// One result word.
	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] addr;
		logic [5:0]  len;
		logic [2:0]  err;
	} result_t;

	// Everything one input byte produces: one result, or two when two is set.
	typedef struct packed {
		logic    two;
		result_t r0;
		result_t r1;
	} entry_t;

	function automatic result_t mk_result(input logic [1:0] kind, input logic [31:0] addr,
		input logic [5:0] len, input logic [2:0] err);
		result_t r;
		r.kind = kind;
		r.addr = addr;
		r.len  = len;
		r.err  = err;
		return r;
	endfunction

endpackage

`default_nettype wire

/* hdl/bup_in_if.sv */
`default_nettype none

interface bup_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic        start_of_message;
	logic [15:0] message_length;

	modport source (output valid, data_byte, start_of_message, message_length, input ready);
	modport sink (input valid, data_byte, start_of_message, message_length, output ready);
endinterface

`default_nettype wire

/* hdl/bup_out_if.sv */
`default_nettype none

interface bup_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  item_kind;
	logic [31:0] prefix_address;
	logic [5:0]  prefix_length;
	logic [2:0]  error_code;
	logic        end_of_results;

	modport source (output valid, item_kind, prefix_address, prefix_length, error_code,
		end_of_results, input ready);
	modport sink (input valid, item_kind, prefix_address, prefix_length, error_code,
		end_of_results, output ready);
endinterface

`default_nettype wire

/* hdl/bup_front.sv */
`default_nettype none

module bup_front
	import bup_pkg::*;
(
	input  wire     clk,
	input  wire     arst_n,
	bup_in_if.sink  bytes_in,
	input  wire     q_full,
	output logic    q_push,
	output entry_t  q_entry
);

	typedef enum logic [3:0] {
		PH_IDLE, PH_WLEN_LO, PH_W_PLEN, PH_W_ADDR, PH_ALEN_HI,
		PH_ALEN_LO, PH_ATTR, PH_N_PLEN, PH_N_ADDR
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [15:0] body_left_q, body_left_n;
	logic [15:0] sect_left_q, sect_left_n;
	logic [7:0]  hi_byte_q, hi_byte_n;
	logic [31:0] acc_q, acc_n;
	logic [5:0]  plen_q, plen_n;
	logic [2:0]  pbytes_q, pbytes_n;

	logic        accept;
	logic [7:0]  b;
	logic [15:0] bl;
	logic [15:0] sl;
	logic [15:0] len16;
	logic [8:0]  nb_wide;
	logic [2:0]  nb;
	logic [15:0] room;
	logic [6:0]  total_wide;
	logic [1:0]  slot;
	logic [31:0] acc_add;
	logic [2:0]  pbytes_dec;
	logic [1:0]  n_res;
	result_t     r0, r1;

	// A byte is taken whenever the queue has a free slot.
	assign bytes_in.ready = !q_full;
	assign accept         = bytes_in.valid && !q_full;
	assign b              = bytes_in.data_byte;

	// Shared field arithmetic for the current byte.
	assign bl         = body_left_q - 16'd1;
	assign sl         = sect_left_q - 16'd1;
	assign len16      = {hi_byte_q, b};
	assign nb_wide    = ({1'b0, b} + 9'd7) >> 3;
	assign nb         = nb_wide[2:0];
	assign room       = (phase_q == PH_W_PLEN) ? sl : bl;
	assign total_wide = ({1'b0, plen_q} + 7'd7) >> 3;
	assign slot       = total_wide[1:0] - pbytes_q[1:0];
	assign pbytes_dec = pbytes_q - 3'd1;

	// Place an address byte, most significant first.
	always_comb begin
		unique case (slot)
			2'd0: acc_add = {b, 24'd0};
			2'd1: acc_add = {8'd0, b, 16'd0};
			2'd2: acc_add = {16'd0, b, 8'd0};
			default: acc_add = {24'd0, b};
		endcase
	end

	// Parser step: next state and the results of this byte.
	always_comb begin
		phase_n     = phase_q;
		body_left_n = body_left_q;
		sect_left_n = sect_left_q;
		hi_byte_n   = hi_byte_q;
		acc_n       = acc_q;
		plen_n      = plen_q;
		pbytes_n    = pbytes_q;
		n_res       = 2'd0;
		r0          = mk_result(KIND_ERROR, 32'd0, 6'd0, ERR_SHORT);
		r1          = mk_result(KIND_ERROR, 32'd0, 6'd0, ERR_SHORT);

		if (bytes_in.start_of_message) begin
			// A new body abandons any unfinished one; both errors are short body.
			n_res = {1'b0, phase_q != PH_IDLE};
			if (bytes_in.message_length < MIN_BODY_BYTES) begin
				n_res   = n_res + 2'd1;
				phase_n = PH_IDLE;
			end else begin
				body_left_n = bytes_in.message_length - 16'd1;
				hi_byte_n   = b;
				phase_n     = PH_WLEN_LO;
			end
		end else if (phase_q != PH_IDLE) begin
			body_left_n = bl;
			unique case (phase_q)
				PH_WLEN_LO: begin
					if ({1'b0, len16} + 17'd2 > {1'b0, bl}) begin
						r0      = mk_result(KIND_ERROR, 32'd0, 6'd0, ERR_WDR_OVFL);
						n_res   = 2'd1;
						phase_n = PH_IDLE;
					end else begin
						sect_left_n = len16;
						phase_n     = (len16 != 16'd0) ? PH_W_PLEN : PH_ALEN_HI;
					end
				end
				PH_W_PLEN, PH_N_PLEN: begin
					if (phase_q == PH_W_PLEN) begin
						sect_left_n = sl;
					end
					if (b > MAX_PREFIX_BITS) begin
						r0      = mk_result(KIND_ERROR, 32'd0, 6'd0, ERR_PLEN_BIG);
						n_res   = 2'd1;
						phase_n = PH_IDLE;
					end else if ({13'd0, nb} > room) begin
						r0      = mk_result(KIND_ERROR, 32'd0, 6'd0, ERR_PFX_OVRRUN);
						n_res   = 2'd1;
						phase_n = PH_IDLE;
					end else if (nb == 3'd0) begin
						// Zero-length prefix is reported right away.
						n_res = 2'd1;
						if (phase_q == PH_W_PLEN) begin
							r0      = mk_result(KIND_WITHDRAWN, 32'd0, 6'd0, ERR_NONE);
							phase_n = (sl == 16'd0) ? PH_ALEN_HI : PH_W_PLEN;
						end else begin
							r0 = mk_result(KIND_ANNOUNCED, 32'd0, 6'd0, ERR_NONE);
							if (bl == 16'd0) begin
								r1      = mk_result(KIND_DONE, 32'd0, 6'd0, ERR_NONE);
								n_res   = 2'd2;
								phase_n = PH_IDLE;
							end
						end
					end else begin
						plen_n   = b[5:0];
						pbytes_n = nb;
						acc_n    = 32'd0;
						phase_n  = (phase_q == PH_W_PLEN) ? PH_W_ADDR : PH_N_ADDR;
					end
				end
				PH_W_ADDR, PH_N_ADDR: begin
					acc_n    = acc_q | acc_add;
					pbytes_n = pbytes_dec;
					if (phase_q == PH_W_ADDR) begin
						sect_left_n = sl;
					end
					if (pbytes_dec == 3'd0) begin
						n_res = 2'd1;
						if (phase_q == PH_W_ADDR) begin
							r0      = mk_result(KIND_WITHDRAWN, acc_q | acc_add, plen_q, ERR_NONE);
							phase_n = (sl != 16'd0) ? PH_W_PLEN : PH_ALEN_HI;
						end else begin
							r0      = mk_result(KIND_ANNOUNCED, acc_q | acc_add, plen_q, ERR_NONE);
							phase_n = PH_N_PLEN;
							if (bl == 16'd0) begin
								r1      = mk_result(KIND_DONE, 32'd0, 6'd0, ERR_NONE);
								n_res   = 2'd2;
								phase_n = PH_IDLE;
							end
						end
					end
				end
				PH_ALEN_HI: begin
					hi_byte_n = b;
					phase_n   = PH_ALEN_LO;
				end
				PH_ALEN_LO: begin
					if (len16 > bl) begin
						r0      = mk_result(KIND_ERROR, 32'd0, 6'd0, ERR_ATTR_OVFL);
						n_res   = 2'd1;
						phase_n = PH_IDLE;
					end else begin
						sect_left_n = len16;
						if (len16 != 16'd0) begin
							phase_n = PH_ATTR;
						end else if (bl == 16'd0) begin
							r0      = mk_result(KIND_DONE, 32'd0, 6'd0, ERR_NONE);
							n_res   = 2'd1;
							phase_n = PH_IDLE;
						end else begin
							phase_n = PH_N_PLEN;
						end
					end
				end
				PH_ATTR: begin
					sect_left_n = sl;
					if (sl == 16'd0) begin
						if (bl == 16'd0) begin
							r0      = mk_result(KIND_DONE, 32'd0, 6'd0, ERR_NONE);
							n_res   = 2'd1;
							phase_n = PH_IDLE;
						end else begin
							phase_n = PH_N_PLEN;
						end
					end
				end
				default: begin
					phase_n = PH_IDLE;
				end
			endcase
		end
	end

	// The results of a byte go to the queue as one entry.
	assign q_push      = accept && (n_res != 2'd0);
	assign q_entry.two = n_res[1];
	assign q_entry.r0  = r0;
	assign q_entry.r1  = r1;

	// Parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			body_left_q <= 16'd0;
			sect_left_q <= 16'd0;
			hi_byte_q   <= 8'd0;
			acc_q       <= 32'd0;
			plen_q      <= 6'd0;
			pbytes_q    <= 3'd0;
		end else if (accept) begin
			phase_q     <= phase_n;
			body_left_q <= body_left_n;
			sect_left_q <= sect_left_n;
			hi_byte_q   <= hi_byte_n;
			acc_q       <= acc_n;
			plen_q      <= plen_n;
			pbytes_q    <= pbytes_n;
		end
	end

endmodule

`default_nettype wire

/* hdl/bup_queue.sv */
`default_nettype none

module bup_queue
	import bup_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  wire    clk,
	input  wire    arst_n,
	input  wire    push,
	input  entry_t push_entry,
	input  wire    pop,
	output logic   full,
	output logic   nonempty,
	output entry_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t          slots_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push, do_pop;

	assign full     = (count_q == CW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign head     = slots_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/bup_back.sv */
`default_nettype none

module bup_back
	import bup_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        q_nonempty,
	input  entry_t     q_head,
	output logic       q_pop,
	bup_out_if.source  results_out
);

	entry_t  hold_q;
	logic    hold_v_q;
	logic    second_q;
	result_t cur;
	logic    last;
	logic    fire;
	logic    advance;

	// The held entry is shown one word at a time.
	assign cur     = second_q ? hold_q.r1 : hold_q.r0;
	assign last    = second_q || !hold_q.two;
	assign fire    = hold_v_q && results_out.ready;
	assign advance = !hold_v_q || (fire && last);
	assign q_pop   = advance && q_nonempty;

	assign results_out.valid          = hold_v_q;
	assign results_out.item_kind      = cur.kind;
	assign results_out.prefix_address = cur.addr;
	assign results_out.prefix_length  = cur.len;
	assign results_out.error_code     = cur.err;
	assign results_out.end_of_results = last;

	// Output register, refilled from the queue as words are taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			second_q <= 1'b0;
			hold_q   <= '0;
		end else if (fire && !last) begin
			second_q <= 1'b1;
		end else if (advance) begin
			hold_v_q <= q_nonempty;
			second_q <= 1'b0;
			if (q_nonempty) begin
				hold_q <= q_head;
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/bgp_update_route_list_parser_top.sv */
// Update message body parser.
// bytes_in carries one body byte per word, with start_of_message set on the
// first byte of a body and message_length valid on that byte. results_out
// carries withdrawn and announced prefixes, a done word at the end of a good
// body, and an error word when parsing stops; end_of_results marks the last
// word that a given input byte caused.
// The front parser takes one byte per cycle while the queue is not full and
// writes the words it causes as one entry into a small queue (QUEUE_DEPTH
// entries). The back stage drains the queue through an output register, one
// word per cycle while results_out.ready is high. A word is written into the
// queue at the edge at which its byte is taken, then loaded into the output
// register once that is free. A byte causing two words holds the back stage
// for both in turn; the queue absorbs this.
// When results_out stalls, the queue fills and bytes_in.ready drops once it
// holds QUEUE_DEPTH entries; no word is lost.
// Reset clears the parser to idle and empties the queue and output register;
// bytes before the next start are ignored.
`default_nettype none

module bgp_update_route_list_parser_top
	import bup_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire        clk,
	input  wire        arst_n,
	bup_in_if.sink     bytes_in,
	bup_out_if.source  results_out
);

	logic   q_full;
	logic   q_push;
	logic   q_pop;
	logic   q_nonempty;
	entry_t q_entry;
	entry_t q_head;

	bup_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.bytes_in (bytes_in),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (q_entry)
	);

	bup_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.pop        (q_pop),
		.full       (q_full),
		.nonempty   (q_nonempty),
		.head       (q_head)
	);

	bup_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_nonempty  (q_nonempty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.results_out (results_out)
	);

	// The parser never writes into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue written while full");

	// The back stage only pops what is there.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_nonempty)
		else $error("pop from empty queue");

	// Only a short-body error can be followed by another word of the same byte.
	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		(results_out.valid && results_out.item_kind == KIND_ERROR
			&& results_out.error_code != ERR_SHORT) |-> results_out.end_of_results)
		else $error("error word not last of its byte");

	// A done word always closes the words of its byte, and carries no error.
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(results_out.valid && results_out.item_kind == KIND_DONE)
			|-> (results_out.end_of_results && results_out.error_code == ERR_NONE))
		else $error("done word malformed");

endmodule

`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
	import bup_pkg::*;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int BYTES_PER_PHASE = 270;
	localparam int DRAIN_CYCLES    = 10;

	// Ways a generated message body is damaged before it is sent.
	localparam int FLAW_NONE      = 0;
	localparam int FLAW_SHORT_LEN = 1;
	localparam int FLAW_LONG_LEN  = 2;
	localparam int FLAW_ANY_LEN   = 3;
	localparam int FLAW_WDR_LEN   = 4;
	localparam int FLAW_ATTR_LEN  = 5;
	localparam int FLAW_PFX_LEN   = 6;
	localparam int FLAW_ANY_BYTE  = 7;
	localparam int FLAW_CUT       = 8;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WDR_LEN_LO,
		ST_WDR_PLEN,
		ST_WDR_ADDR,
		ST_ATTR_LEN_HI,
		ST_ATTR_LEN_LO,
		ST_ATTR_SKIP,
		ST_ANN_PLEN,
		ST_ANN_ADDR
	} parse_state_t;

	typedef struct packed {
		logic [7:0]  data;
		logic        first;
		logic [15:0] body_len;
	} body_byte_t;

	typedef struct packed {
		result_t r;
		logic    last;
	} parser_word_t;

	logic clk;
	logic arst_n;

	bup_in_if  bytes_if();
	bup_out_if results_if();

	bgp_update_route_list_parser_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.bytes_in   (bytes_if),
		.results_out(results_if)
	);

	// Bytes waiting for the driver and words the parser owes us.
	body_byte_t   pending_bytes[$];
	parser_word_t expected_words[$];
	result_t      step_words[$];
	body_byte_t   next_byte;

	logic [7:0] msg_body[$];
	int         len_spots[$];

	int queued_count      = 0;
	int accepted_count    = 0;
	int words_seen        = 0;
	int mismatch_count    = 0;
	int cycle_count       = 0;
	int sender_idle_pct   = 0;
	int receiver_idle_pct = 0;

	// Our own copy of the parser state.
	parse_state_t parse_state    = ST_IDLE;
	logic [15:0]  body_left      = '0;
	logic [15:0]  sect_left      = '0;
	logic [7:0]   hi_byte        = '0;
	logic [31:0]  addr_acc       = '0;
	logic [5:0]   pfx_bits       = '0;
	logic [2:0]   pfx_bytes_left = '0;

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("mismatch at word %0d: %s", words_seen, what);
	endtask

	task automatic add_word(input logic [1:0] k, input logic [31:0] a, input logic [5:0] l,
		input logic [2:0] e);
		result_t w;
		w.kind = k;
		w.addr = a;
		w.len  = l;
		w.err  = e;
		step_words.insert(step_words.size(), w);
	endtask

	task automatic parse_error(input logic [2:0] e);
		parse_state = ST_IDLE;
		add_word(KIND_ERROR, '0, '0, e);
	endtask

	// A prefix length byte; room is the number of bytes left in its list.
	task automatic take_prefix_len(input logic [7:0] b, input int room, input logic [1:0] k,
		input parse_state_t addr_state);
		int nbytes;
		nbytes = (int'(b) + 7) / 8;
		if (b > MAX_PREFIX_BITS) begin
			parse_error(ERR_PLEN_BIG);
		end else if (nbytes > room) begin
			parse_error(ERR_PFX_OVRRUN);
		end else if (nbytes == 0) begin
			add_word(k, '0, '0, ERR_NONE);
		end else begin
			pfx_bits       = b[5:0];
			pfx_bytes_left = nbytes[2:0];
			addr_acc       = '0;
			parse_state    = addr_state;
		end
	endtask

	// Packs one address byte from the top down; true when the prefix is complete.
	function automatic logic take_addr_byte(input logic [7:0] b);
		int total;
		int idx;
		total = (int'(pfx_bits) + 7) / 8;
		idx = (total - int'(pfx_bytes_left)) & 3;
		addr_acc = addr_acc | (32'(b) << (24 - 8 * idx));
		pfx_bytes_left = pfx_bytes_left - 3'd1;
		return pfx_bytes_left == 3'd0;
	endfunction

	task automatic enter_announced();
		if (body_left == 16'd0) begin
			parse_state = ST_IDLE;
			add_word(KIND_DONE, '0, '0, ERR_NONE);
		end else begin
			parse_state = ST_ANN_PLEN;
		end
	endtask

	// Works out the words that one accepted byte causes and queues them.
	task automatic predict_parser_words(input logic [7:0] b, input logic first,
		input logic [15:0] blen);
		logic [15:0]  field;
		parser_word_t pw;
		step_words = {};
		if (first) begin
			if (parse_state != ST_IDLE) parse_error(ERR_SHORT);
			if (blen < MIN_BODY_BYTES) begin
				parse_error(ERR_SHORT);
			end else begin
				body_left   = blen - 16'd1;
				hi_byte     = b;
				parse_state = ST_WDR_LEN_LO;
			end
		end else if (parse_state != ST_IDLE) begin
			body_left = body_left - 16'd1;
			case (parse_state)
				ST_WDR_LEN_LO: begin
					field = {hi_byte, b};
					if (int'(field) + 2 > int'(body_left)) begin
						parse_error(ERR_WDR_OVFL);
					end else begin
						sect_left   = field;
						parse_state = (field != 16'd0) ? ST_WDR_PLEN : ST_ATTR_LEN_HI;
					end
				end
				ST_WDR_PLEN: begin
					sect_left = sect_left - 16'd1;
					take_prefix_len(b, int'(sect_left), KIND_WITHDRAWN, ST_WDR_ADDR);
					if (parse_state == ST_WDR_PLEN && sect_left == 16'd0) begin
						parse_state = ST_ATTR_LEN_HI;
					end
				end
				ST_WDR_ADDR: begin
					sect_left = sect_left - 16'd1;
					if (take_addr_byte(b)) begin
						add_word(KIND_WITHDRAWN, addr_acc, pfx_bits, ERR_NONE);
						parse_state = (sect_left != 16'd0) ? ST_WDR_PLEN : ST_ATTR_LEN_HI;
					end
				end
				ST_ATTR_LEN_HI: begin
					hi_byte     = b;
					parse_state = ST_ATTR_LEN_LO;
				end
				ST_ATTR_LEN_LO: begin
					field = {hi_byte, b};
					if (field > body_left) begin
						parse_error(ERR_ATTR_OVFL);
					end else begin
						sect_left = field;
						if (field != 16'd0) parse_state = ST_ATTR_SKIP;
						else enter_announced();
					end
				end
				ST_ATTR_SKIP: begin
					sect_left = sect_left - 16'd1;
					if (sect_left == 16'd0) enter_announced();
				end
				ST_ANN_PLEN: begin
					take_prefix_len(b, int'(body_left), KIND_ANNOUNCED, ST_ANN_ADDR);
					if (parse_state == ST_ANN_PLEN) enter_announced();
				end
				ST_ANN_ADDR: begin
					if (take_addr_byte(b)) begin
						add_word(KIND_ANNOUNCED, addr_acc, pfx_bits, ERR_NONE);
						enter_announced();
					end
				end
				default: begin
					parse_state = ST_IDLE;
				end
			endcase
		end
		foreach (step_words[i]) begin
			pw.r    = step_words[i];
			pw.last = (i == step_words.size() - 1);
			expected_words.insert(expected_words.size(), pw);
		end
	endtask

	// Compares one received word with the oldest expected one.
	task automatic check_word();
		parser_word_t want;
		words_seen++;
		if (expected_words.size() == 0) begin
			report_mismatch($sformatf("unexpected word, kind %0d", results_if.item_kind));
			return;
		end
		want = expected_words.pop_front();
		if (results_if.item_kind !== want.r.kind)
			report_mismatch($sformatf("kind %0d, expected %0d",
				results_if.item_kind, want.r.kind));
		if (results_if.prefix_address !== want.r.addr)
			report_mismatch($sformatf("address %h, expected %h",
				results_if.prefix_address, want.r.addr));
		if (results_if.prefix_length !== want.r.len)
			report_mismatch($sformatf("length %0d, expected %0d",
				results_if.prefix_length, want.r.len));
		if (results_if.error_code !== want.r.err)
			report_mismatch($sformatf("error code %0d, expected %0d",
				results_if.error_code, want.r.err));
		if (results_if.end_of_results !== want.last)
			report_mismatch($sformatf("end_of_results %0d, expected %0d",
				results_if.end_of_results, want.last));
	endtask

	task automatic queue_byte(input logic [7:0] data, input logic first, input logic [15:0] blen);
		body_byte_t item;
		item.data     = data;
		item.first    = first;
		item.body_len = blen;
		pending_bytes.insert(pending_bytes.size(), item);
		queued_count++;
	endtask

	// Sends msg_body as one body; the length only rides on the first byte.
	task automatic queue_body(input logic [15:0] blen);
		foreach (msg_body[i]) begin
			queue_byte(msg_body[i], i == 0, (i == 0) ? blen : 16'($urandom));
		end
	endtask

	task automatic append_prefixes(input int count);
		int bits;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(9))
				0: bits = 0;
				1: bits = 32;
				default: bits = $urandom_range(32);
			endcase
			len_spots.insert(len_spots.size(), msg_body.size());
			msg_body.insert(msg_body.size(), 8'(bits));
			for (int j = 0; j < (bits + 7) / 8; j++)
				msg_body.insert(msg_body.size(), 8'($urandom));
		end
	endtask

	// Builds a well-formed body with random content, then maybe damages it.
	task automatic queue_message(input int n_wdr, input int n_attr, input int n_ann,
		input int flaw);
		int          wdr_size;
		int          alen_at;
		logic [15:0] blen;
		msg_body  = {};
		len_spots = {};
		msg_body.insert(msg_body.size(), 8'h00);
		msg_body.insert(msg_body.size(), 8'h00);
		append_prefixes(n_wdr);
		wdr_size    = msg_body.size() - 2;
		msg_body[0] = 8'(wdr_size >> 8);
		msg_body[1] = 8'(wdr_size);
		alen_at = msg_body.size();
		msg_body.insert(msg_body.size(), 8'(n_attr >> 8));
		msg_body.insert(msg_body.size(), 8'(n_attr));
		repeat (n_attr) msg_body.insert(msg_body.size(), 8'($urandom));
		append_prefixes(n_ann);
		blen = 16'(msg_body.size());
		case (flaw)
			FLAW_SHORT_LEN: blen = 16'($urandom_range(msg_body.size() - 1));
			FLAW_LONG_LEN: blen = blen + 16'($urandom_range(1, 20));
			FLAW_ANY_LEN: blen = 16'($urandom);
			FLAW_WDR_LEN: begin
				if ($urandom_range(1) == 0) msg_body[0] = 8'($urandom);
				msg_body[1] = 8'($urandom);
			end
			FLAW_ATTR_LEN: begin
				if ($urandom_range(1) == 0) msg_body[alen_at] = 8'($urandom);
				msg_body[alen_at + 1] = 8'($urandom);
			end
			FLAW_PFX_LEN: begin
				if (len_spots.size() != 0)
					msg_body[len_spots[$urandom_range(len_spots.size() - 1)]] =
						8'($urandom_range(1, 255));
			end
			FLAW_ANY_BYTE: msg_body[$urandom_range(msg_body.size() - 1)] = 8'($urandom);
			FLAW_CUT: repeat ($urandom_range(1, msg_body.size() - 1)) void'(msg_body.pop_back());
			default: ;
		endcase
		queue_body(blen);
	endtask

	// Short directed run over the extremes and each error path.
	task automatic queue_directed();
		// A stray byte while idle is ignored.
		queue_byte(8'hA5, 1'b0, 16'hFFFF);
		// A full /32 withdrawn prefix, one attribute byte, announced /0 and /1.
		msg_body = {8'h00, 8'h05, 8'h20, 8'hAA, 8'hBB, 8'hCC, 8'hDD,
			8'h00, 8'h01, 8'h5A, 8'h00, 8'h01, 8'h80};
		queue_body(16'd13);
		// Attribute length past the end of the body.
		msg_body = {8'h00, 8'h00, 8'h00, 8'h09};
		queue_body(16'd4);
		// Withdrawn length too large for the body.
		msg_body = {8'h00, 8'h05};
		queue_body(16'd4);
		// Prefix length of 33.
		msg_body = {8'h00, 8'h01, 8'h21};
		queue_body(16'd5);
		// Prefix that needs a byte its list does not have.
		msg_body = {8'h00, 8'h01, 8'h08};
		queue_body(16'd5);
		// Longest body cut off by a new start that is itself too short.
		msg_body = {8'h00, 8'h01};
		queue_body(16'hFFFF);
		queue_byte(8'h00, 1'b1, 16'd2);
	endtask

	// Clock and the known input values at time zero.
	initial begin
		clk                         = 1'b0;
		arst_n                      = 1'b0;
		bytes_if.valid              = 1'b0;
		bytes_if.data_byte          = '0;
		bytes_if.start_of_message   = 1'b0;
		bytes_if.message_length     = '0;
		results_if.ready            = 1'b0;
		forever #5 clk = ~clk;
	end

	// Byte driver; each accepted byte is run through the predictor.
	always @(posedge clk) begin
		if (!arst_n) begin
			bytes_if.valid <= 1'b0;
		end else begin
			if (bytes_if.valid && bytes_if.ready) begin
				predict_parser_words(bytes_if.data_byte, bytes_if.start_of_message,
					bytes_if.message_length);
				accepted_count++;
			end
			if (!bytes_if.valid || bytes_if.ready) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					next_byte = pending_bytes.pop_front();
					bytes_if.valid            <= 1'b1;
					bytes_if.data_byte        <= next_byte.data;
					bytes_if.start_of_message <= next_byte.first;
					bytes_if.message_length   <= next_byte.body_len;
				end else begin
					bytes_if.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor with a randomly stalling ready.
	always @(posedge clk) begin
		if (!arst_n) begin
			results_if.ready <= 1'b0;
		end else begin
			if (results_if.valid && results_if.ready) check_word();
			results_if.ready <= ($urandom_range(99) >= receiver_idle_pct);
		end
	end

	// Hard stop if the run hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// Three stall phases: slow receiver, slow sender, then full rate.
	initial begin
		int phase_bytes;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					sender_idle_pct   = 6;
					receiver_idle_pct = 57;
				end
				1: begin
					sender_idle_pct   = 57;
					receiver_idle_pct = 6;
				end
				default: begin
					sender_idle_pct   = 0;
					receiver_idle_pct = 0;
				end
			endcase
			if (p == 0) queue_directed();
			phase_bytes = 0;
			while (phase_bytes < BYTES_PER_PHASE) begin
				if ($urandom_range(7) == 0)
					repeat ($urandom_range(1, 3)) queue_byte(8'($urandom), 1'b0, 16'($urandom));
				queue_message($urandom_range(0, 3), $urandom_range(0, 6), $urandom_range(0, 4),
					($urandom_range(99) < 65) ? FLAW_NONE : $urandom_range(FLAW_SHORT_LEN, FLAW_CUT));
				phase_bytes += msg_body.size();
			end
			while (accepted_count != queued_count) @(posedge clk);
		end
		while (expected_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule

/* files.f */
hdl/bup_pkg.sv
hdl/bup_in_if.sv
hdl/bup_out_if.sv
hdl/bup_front.sv
hdl/bup_queue.sv
hdl/bup_back.sv
hdl/bgp_update_route_list_parser_top.sv
test/tb_top.sv
